FILE: design/art_pkg.sv
// ----------------------------------------------------------------------------
// Axis rotation transform package
// Shared types and constants for the elementary axis rotation block: the
// transfer payloads, axis codes, fixed-point widths and the arctangent table.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int COORD_BITS = 16;
    localparam int MAT_BITS   = 16;

    // Internal CORDIC widths: Q1.30 vectors with growth headroom, 32-bit angles.
    localparam int XY_W  = 33;
    localparam int Z_W   = 32;
    localparam int RND_W = XY_W + 1;
    localparam int Q_W   = RND_W - 16;

    localparam int ATAN_MAX = 30;

    localparam logic signed [XY_W-1:0] GAIN_Q30  = 33'sd652032875;
    localparam logic signed [MAT_BITS-1:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [MAT_BITS-1:0] ZERO_Q14 = 16'sd0;
    localparam logic signed [Q_W-1:0] SAT_HI = 18'sd16384;
    localparam logic signed [Q_W-1:0] SAT_LO = -18'sd16384;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // Arctangent of 2^-i in units of 2^-32 turn, rounded to nearest.
    localparam logic [Z_W-1:0] ATAN_TAB [ATAN_MAX] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    typedef struct packed {
        logic [1:0]                   axis_select;
        logic [ANGLE_BITS-1:0]        turn_angle;
        logic signed [COORD_BITS-1:0] shift_x;
        logic signed [COORD_BITS-1:0] shift_y;
        logic signed [COORD_BITS-1:0] shift_z;
    } item_t;

    typedef struct packed {
        logic signed [MAT_BITS-1:0]   m00;
        logic signed [MAT_BITS-1:0]   m01;
        logic signed [MAT_BITS-1:0]   m02;
        logic signed [MAT_BITS-1:0]   m10;
        logic signed [MAT_BITS-1:0]   m11;
        logic signed [MAT_BITS-1:0]   m12;
        logic signed [MAT_BITS-1:0]   m20;
        logic signed [MAT_BITS-1:0]   m21;
        logic signed [MAT_BITS-1:0]   m22;
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
    } result_t;

endpackage

FILE: design/axis_rotation_transform.sv
// ----------------------------------------------------------------------------
// Axis rotation transform
// Throughput: one transfer per cycle while result_stall is low; the unrolled CORDIC pipeline sets this.
// Each stage advances independently, so bubbles close up under a result stall.
// Reset (rst_n low, asynchronous) clears every stage valid bit; data is not reset.
// ----------------------------------------------------------------------------
// Forms the rotation block and translation column of a homogeneous transform
// for a rotation about X, Y or Z by a 16-bit binary angle.
// ----------------------------------------------------------------------------
module axis_rotation_transform
    import art_pkg::*;
#(
    parameter int CORDIC_STAGES = 14
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // Stage map: 0 holds the prepared angle, 1..CORDIC_STAGES hold the state
    // after each micro-rotation, RND_S holds the rounded and quadrant-corrected
    // cosine and sine, OUT_S is the output register.
    localparam int RND_S = CORDIC_STAGES + 1;
    localparam int OUT_S = CORDIC_STAGES + 2;
    localparam int NUM_S = CORDIC_STAGES + 3;

    logic [NUM_S-1:0] valid_reg;
    logic [NUM_S:0]   ready;

    // Payload that rides alongside the CORDIC.
    logic [1:0]                   axis_reg  [0:RND_S];
    logic [1:0]                   quad_reg  [0:CORDIC_STAGES];
    logic signed [COORD_BITS-1:0] sx_reg    [0:RND_S];
    logic signed [COORD_BITS-1:0] sy_reg    [0:RND_S];
    logic signed [COORD_BITS-1:0] sz_reg    [0:RND_S];
    logic signed [XY_W-1:0]       x_reg     [0:CORDIC_STAGES];
    logic signed [XY_W-1:0]       y_reg     [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]        z_reg     [0:CORDIC_STAGES];

    logic signed [MAT_BITS-1:0] cos_reg;
    logic signed [MAT_BITS-1:0] sin_reg;
    result_t                    result_reg;

    // A stage can take a new item when it is empty or its item moves on in
    // the same cycle. The last link is the downstream stall.
    assign ready[NUM_S] = !result_stall;

    for (genvar k = 0; k < NUM_S; k++) begin : g_ready
        assign ready[k] = !valid_reg[k] || ready[k+1];
    end

    assign item_stall   = !ready[0];
    assign result_valid = valid_reg[OUT_S];
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= item_valid;
            end
            for (int k = 1; k < NUM_S; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: align the angle to 32 bits and add an eighth of a turn, so
    // the top two bits give the quadrant and the rest a residual angle in
    // [-1/8, 1/8) turn for the CORDIC.
    // ------------------------------------------------------------------
    logic [Z_W-1:0]        angle_next;
    logic signed [Z_W-1:0] z_next;

    always_comb
    begin
        angle_next = {item.turn_angle, {(Z_W - ANGLE_BITS){1'b0}}} + 32'h2000_0000;
        z_next     = signed'({2'b00, angle_next[Z_W-3:0]}) - 32'sh2000_0000;
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            axis_reg[0] <= item.axis_select;
            quad_reg[0] <= angle_next[Z_W-1:Z_W-2];
            sx_reg[0]   <= item.shift_x;
            sy_reg[0]   <= item.shift_y;
            sz_reg[0]   <= item.shift_z;
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC micro-rotations, one per stage. The shifts are arithmetic and
    // so round toward minus infinity.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
        logic signed [XY_W-1:0] x_next;
        logic signed [XY_W-1:0] y_next;
        logic signed [Z_W-1:0]  zi_next;
        logic signed [Z_W-1:0]  atan_step;

        always_comb
        begin
            atan_step = signed'(ATAN_TAB[i]);
            if (!z_reg[i][Z_W-1])
            begin
                x_next  = x_reg[i] - (y_reg[i] >>> i);
                y_next  = y_reg[i] + (x_reg[i] >>> i);
                zi_next = z_reg[i] - atan_step;
            end
            else
            begin
                x_next  = x_reg[i] + (y_reg[i] >>> i);
                y_next  = y_reg[i] - (x_reg[i] >>> i);
                zi_next = z_reg[i] + atan_step;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready[i+1])
            begin
                axis_reg[i+1] <= axis_reg[i];
                quad_reg[i+1] <= quad_reg[i];
                sx_reg[i+1]   <= sx_reg[i];
                sy_reg[i+1]   <= sy_reg[i];
                sz_reg[i+1]   <= sz_reg[i];
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= zi_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Round Q1.30 to Q1.14 (add half an LSB, floor), clamp to +/-1.0, then
    // fold in the quadrant by swapping and negating cosine and sine.
    // ------------------------------------------------------------------
    logic signed [RND_W-1:0]    xr_sum;
    logic signed [RND_W-1:0]    yr_sum;
    logic signed [Q_W-1:0]      xr_q;
    logic signed [Q_W-1:0]      yr_q;
    logic signed [MAT_BITS-1:0] cr;
    logic signed [MAT_BITS-1:0] sr;
    logic signed [MAT_BITS-1:0] cos_next;
    logic signed [MAT_BITS-1:0] sin_next;

    always_comb
    begin
        xr_sum = RND_W'(x_reg[CORDIC_STAGES]) + RND_W'(32768);
        yr_sum = RND_W'(y_reg[CORDIC_STAGES]) + RND_W'(32768);
        xr_q   = xr_sum[RND_W-1:16];
        yr_q   = yr_sum[RND_W-1:16];

        if (xr_q > SAT_HI)
            cr = ONE_Q14;
        else if (xr_q < SAT_LO)
            cr = -ONE_Q14;
        else
            cr = xr_q[MAT_BITS-1:0];

        if (yr_q > SAT_HI)
            sr = ONE_Q14;
        else if (yr_q < SAT_LO)
            sr = -ONE_Q14;
        else
            sr = yr_q[MAT_BITS-1:0];

        case (quad_reg[CORDIC_STAGES])
            QUAD_0:
            begin
                cos_next = cr;
                sin_next = sr;
            end
            QUAD_1:
            begin
                cos_next = -sr;
                sin_next = cr;
            end
            QUAD_2:
            begin
                cos_next = -cr;
                sin_next = -sr;
            end
            default:
            begin
                cos_next = sr;
                sin_next = -cr;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ready[RND_S])
        begin
            axis_reg[RND_S] <= axis_reg[CORDIC_STAGES];
            sx_reg[RND_S]   <= sx_reg[CORDIC_STAGES];
            sy_reg[RND_S]   <= sy_reg[CORDIC_STAGES];
            sz_reg[RND_S]   <= sz_reg[CORDIC_STAGES];
            cos_reg         <= cos_next;
            sin_reg         <= sin_next;
        end
    end

    // ------------------------------------------------------------------
    // Matrix assembly. Start from the identity and place cosine and sine
    // according to the axis; the unused axis code keeps the identity.
    // ------------------------------------------------------------------
    result_t result_next;

    always_comb
    begin
        result_next       = '0;
        result_next.m00   = ONE_Q14;
        result_next.m01   = ZERO_Q14;
        result_next.m02   = ZERO_Q14;
        result_next.m10   = ZERO_Q14;
        result_next.m11   = ONE_Q14;
        result_next.m12   = ZERO_Q14;
        result_next.m20   = ZERO_Q14;
        result_next.m21   = ZERO_Q14;
        result_next.m22   = ONE_Q14;
        result_next.out_x = sx_reg[RND_S];
        result_next.out_y = sy_reg[RND_S];
        result_next.out_z = sz_reg[RND_S];

        case (axis_reg[RND_S])
            AXIS_X:
            begin
                result_next.m11 = cos_reg;
                result_next.m12 = -sin_reg;
                result_next.m21 = sin_reg;
                result_next.m22 = cos_reg;
            end
            AXIS_Y:
            begin
                result_next.m00 = cos_reg;
                result_next.m02 = sin_reg;
                result_next.m20 = -sin_reg;
                result_next.m22 = cos_reg;
            end
            AXIS_Z:
            begin
                result_next.m00 = cos_reg;
                result_next.m01 = -sin_reg;
                result_next.m10 = sin_reg;
                result_next.m11 = cos_reg;
            end
            default:
            begin
                result_next.m00 = ONE_Q14;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ready[OUT_S])
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The input is held off only when every stage is full and the output is blocked.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> ((&valid_reg) && result_stall))
        else $error("input stalled while the pipeline has room");

    // Rounded cosine and sine stay within +/-1.0 in Q1.14.
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[RND_S] |-> (cos_reg <= ONE_Q14 && cos_reg >= -ONE_Q14 &&
                              sin_reg <= ONE_Q14 && sin_reg >= -ONE_Q14))
        else $error("cosine or sine out of range");

    // The diagonal entry of the rotation axis is fixed at 1.0, so at least one
    // diagonal entry of a delivered matrix is always 1.0.
    a_diag_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.m00 == ONE_Q14 || result.m11 == ONE_Q14 ||
                          result.m22 == ONE_Q14))
        else $error("rotation matrix has no unit axis");

    // An item that leaves the output stage was replaced or the stage emptied.
    a_output_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !valid_reg[RND_S]) |=> !result_valid)
        else $error("result repeated after transfer");

endmodule

FILE: dv/transform_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Axis rotation transform checker
// Watches both channels of the block. Every input transfer gets a predicted
// transform from a fixed-length CORDIC model, and every result transfer is
// compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module transform_checker
    import art_pkg::*;
#(
    parameter int CORDIC_STAGES = 14
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      fail_count,
    output int      pending
);

    localparam int NUM_FIELDS = 12;
    localparam longint GAIN_START = 64'sd652032875;
    localparam longint ONE_EIGHTH = 64'sd536870912;

    string field_name [NUM_FIELDS] = '{
        "m00", "m01", "m02", "m10", "m11", "m12",
        "m20", "m21", "m22", "out_x", "out_y", "out_z"
    };

    result_t expected_transforms [$];
    int      errors;

    // Rounds a Q1.30 value to Q1.14 and clamps it to plus or minus one.
    function automatic logic signed [15:0] round_to_q14(longint v);
        longint r;
        r = (v + 64'sd32768) >>> 16;
        if (r > 64'sd16384)
            r = 64'sd16384;
        if (r < -64'sd16384)
            r = -64'sd16384;
        return 16'(r);
    endfunction

    function automatic result_t predict_transform(item_t it);
        result_t             r;
        logic [31:0]         turn;
        longint              x;
        longint              y;
        longint              z;
        longint              dx;
        longint              dy;
        logic signed [15:0]  cos_r;
        logic signed [15:0]  sin_r;
        logic signed [15:0]  cos_v;
        logic signed [15:0]  sin_v;
        turn = {it.turn_angle, 16'h0000} + 32'h2000_0000;
        z = $signed({34'd0, turn[29:0]}) - ONE_EIGHTH;
        x = GAIN_START;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TAB[i]);
            end
        end
        cos_r = round_to_q14(x);
        sin_r = round_to_q14(y);
        // The quadrant is folded back in exactly by swapping and negating.
        case (turn[31:30])
            QUAD_0:
            begin
                cos_v = cos_r;
                sin_v = sin_r;
            end
            QUAD_1:
            begin
                cos_v = -sin_r;
                sin_v = cos_r;
            end
            QUAD_2:
            begin
                cos_v = -cos_r;
                sin_v = -sin_r;
            end
            default:
            begin
                cos_v = sin_r;
                sin_v = -cos_r;
            end
        endcase
        r     = '0;
        r.m00 = ONE_Q14;
        r.m11 = ONE_Q14;
        r.m22 = ONE_Q14;
        case (it.axis_select)
            AXIS_X:
            begin
                r.m11 = cos_v;
                r.m12 = -sin_v;
                r.m21 = sin_v;
                r.m22 = cos_v;
            end
            AXIS_Y:
            begin
                r.m00 = cos_v;
                r.m02 = sin_v;
                r.m20 = -sin_v;
                r.m22 = cos_v;
            end
            AXIS_Z:
            begin
                r.m00 = cos_v;
                r.m01 = -sin_v;
                r.m10 = sin_v;
                r.m11 = cos_v;
            end
            default:
            begin
                // The unused axis code keeps the identity rotation.
            end
        endcase
        r.out_x = it.shift_x;
        r.out_y = it.shift_y;
        r.out_z = it.shift_z;
        return r;
    endfunction

    initial
    begin
        errors     = 0;
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        result_t     want;
        logic [15:0] e;
        logic [15:0] a;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                expected_transforms.push_back(predict_transform(item));
            if (result_valid && !result_stall)
            begin
                if (expected_transforms.size() == 0)
                begin
                    errors++;
                    $display("%0t ERROR unexpected result transfer, expected none, got %h",
                             $time, result);
                end
                else
                begin
                    want = expected_transforms.pop_front();
                    for (int k = 0; k < NUM_FIELDS; k++)
                    begin
                        e = want[16*(NUM_FIELDS-k)-1 -: 16];
                        a = result[16*(NUM_FIELDS-k)-1 -: 16];
                        if (a !== e)
                        begin
                            errors++;
                            $display("%0t ERROR field %s expected %0d got %0d",
                                     $time, field_name[k], $signed(e), $signed(a));
                        end
                    end
                end
            end
            fail_count <= errors;
            pending    <= expected_transforms.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Axis rotation transform testbench
// Drives axis/angle/translation transfers into the block and lets the checker
// predict and compare every transform. A directed set covers the quadrant
// boundaries, all four axis codes and the translation extremes; a random set
// follows, with random idling on both sides, a quiet stretch, a long result
// hold-off that backs the pipeline up, and a pause that drains it.
// ----------------------------------------------------------------------------
module testbench;
    import art_pkg::*;

    localparam int RANDOM_ITEMS  = 550;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 40;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    int mismatches;
    int outstanding;
    int sent_count;

    // Both sides idle at random only while this is set.
    bit idle_enable;
    // Raised by the stimulus to ask the result side for a long hold-off.
    bit hold_request;

    axis_rotation_transform u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    transform_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (mismatches),
        .pending      (outstanding)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request. The
    // hold-off is counted here so the sender keeps pushing while it lasts.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                result_stall <= idle_enable && ($urandom_range(99) < 6);
            end
        end
    end

    // Presents one transfer and returns at the clock edge that accepts it.
    // The valid stays high into the next call unless an idle cycle is drawn,
    // so back-to-back transfers never drop it.
    task automatic send_transform(item_t it);
        @(negedge clk);
        while (idle_enable && ($urandom_range(99) < 6))
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // Random transfer: angles are mostly uniform, with some near the octant
    // and quadrant boundaries where the CORDIC residual changes sign.
    function automatic item_t random_transform();
        item_t it;
        int    pick;
        pick           = $urandom_range(9);
        it.axis_select = 2'($urandom_range(3));
        if (pick < 3)
            it.turn_angle = 16'($urandom_range(7) * 32'h2000 + $urandom_range(4) - 2);
        else
            it.turn_angle = 16'($urandom);
        if (pick == 9)
        begin
            it.shift_x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            it.shift_y = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            it.shift_z = $urandom_range(1) ? 16'sh0000 : 16'shFFFF;
        end
        else
        begin
            it.shift_x = 16'($urandom);
            it.shift_y = 16'($urandom);
            it.shift_z = 16'($urandom);
        end
        return it;
    endfunction

    initial
    begin
        logic signed [15:0] shift_edges [4];
        logic [15:0]        angle_edges [6];
        item_t              it;
        shift_edges  = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        idle_enable  = 1'b1;
        hold_request = 1'b0;
        sent_count   = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: every axis code, including the one that keeps the
        // identity, at zero, each quarter turn, the octant edge and the
        // largest angle, with the translation fields at their extremes.
        for (int a = 0; a < 4; a++)
        begin
            angle_edges = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                            (a % 2) ? 16'h1FFF : 16'h2000, 16'hFFFF};
            for (int k = 0; k < 6; k++)
            begin
                it.axis_select = 2'(a);
                it.turn_angle  = angle_edges[k];
                it.shift_x     = shift_edges[(a + k) % 4];
                it.shift_y     = shift_edges[(a + k + 1) % 4];
                it.shift_z     = shift_edges[(a + k + 2) % 4];
                send_transform(it);
            end
        end

        // Random part with a quiet stretch, a long hold-off on the result
        // side while transfers keep coming, and a full drain pause.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 100)
                idle_enable = 1'b0;
            if (n == 180)
                idle_enable = 1'b1;
            if (n == 250)
            begin
                idle_enable  = 1'b0;
                hold_request = 1'b1;
            end
            if (n == 320)
                idle_enable = 1'b1;
            if (n == 400)
            begin
                // Drop the valid so the last transfer is not taken again.
                @(negedge clk);
                item_valid <= 1'b0;
                do
                    @(posedge clk);
                while (outstanding != 0);
            end
            send_transform(random_transform());
        end
        @(negedge clk);
        item_valid <= 1'b0;

        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d transforms across all four axis codes, quadrant edges and", sent_count);
        $display("translation extremes, with random idling, a result hold-off and a drain.");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
